FILE: design/assert_macros.svh
// Assertion macros for the sparse logistic trainer.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SLT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("slt assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define SLT_ASSERT_IMPLY(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error("slt implication failed");

`endif

FILE: design/slt_pkg.sv
// Package for the sparse logistic trainer: sizes, codes, shared types,
// the sigmoid table and small arithmetic helpers. No dependencies.
package slt_pkg;

  localparam int NUM_FEATURES    = 4096;  // power of two: index wraps by mask
  localparam int MAX_ACTIVE      = 64;
  localparam int SIGMOID_ENTRIES = 1024;

  localparam int W_AW   = $clog2(NUM_FEATURES);
  localparam int BUF_AW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
  localparam int CNT_W  = $clog2(MAX_ACTIVE + 1);
  localparam int SIG_AW = $clog2(SIGMOID_ENTRIES);
  localparam int ACC_W  = 52 + CNT_W;
  localparam int N_W    = 20 + SIG_AW + 1;
  localparam int X_W    = N_W - 18;

  localparam longint SIX_Q16    = 393216;
  localparam longint TWELVE_Q16 = 786432;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 17;

  typedef enum logic [1:0] {
    OP_FEATURE     = 2'd0,
    OP_SAMPLE_END  = 2'd1,
    OP_EPOCH_END   = 2'd2,
    OP_WEIGHT_READ = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_PRED  = 2'd0,
    KIND_EPOCH = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic {
    IT_DIV  = 1'b0,
    IT_SQRT = 1'b1
  } iter_op_e;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_DOT_BRD, ST_DOT_WRD, ST_DOT_MUL, ST_DOT_ACC,
    ST_SIG0, ST_SIG1, ST_SIG2,
    ST_RG_MUL, ST_RG_CAP,
    ST_UPD_BRD, ST_UPD_WRD, ST_UPD_MUL, ST_UPD_WR,
    ST_EP_MUL, ST_EP_DIV, ST_EP_DIVW,
    ST_SW_RD, ST_SW_WR,
    ST_EP_BIAS, ST_EP_RATE, ST_EP_RATEW, ST_EP_SQW,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic        start;
    iter_op_e    op;
    logic [63:0] a;
    logic [32:0] b;
  } iter_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } iter_rsp_t;

  typedef logic [16:0] sig_tab_t [SIGMOID_ENTRIES];

  // Divide by shift and subtract, one quotient bit per step
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Build the sigmoid table at elaboration
  function automatic sig_tab_t build_sig_table();
    sig_tab_t tab;
    longint unsigned span, t, y, y2, y3, y4, r, den, p;
    longint zk;
    span = longint'(SIGMOID_ENTRIES - 1);
    for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
      zk = longint'(udiv64(longint'(k) * TWELVE_Q16 + span / 2, span)) - SIX_Q16;
      t  = (zk < 0) ? -zk : zk;
      y  = t << 8;
      y2 = (y * y) >> 30;
      y3 = (y2 * y) >> 30;
      y4 = (y3 * y) >> 30;
      r  = 64'd1073741824 - y + y2 / 2 - y3 / 6 + y4 / 24;
      for (int i = 0; i < 6; i++) begin
        r = (r * r + 64'd536870912) >> 30;
      end
      den = 64'd1073741824 + r;
      p   = udiv64((64'd1 << 46) + (den >> 1), den);
      if (zk < 0) p = 64'd65536 - p;
      tab[k] = p[16:0];
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

  // Saturate a wide signed value to 32 bits
  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -36'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Move a value toward zero by thr, clearing it inside the band
  function automatic logic [31:0] soft_thr(input logic signed [31:0] v,
                                           input logic [31:0] thr);
    logic [32:0] mag;
    logic signed [33:0] res;
    mag = v[31] ? 33'(-34'(v)) : 33'(v);
    res = v[31] ? (34'(v) + $signed({2'b00, thr})) : (34'(v) - $signed({2'b00, thr}));
    if (mag <= {1'b0, thr}) return 32'd0;
    return res[31:0];
  endfunction

  // Wrap a feature id into the table
  function automatic logic [W_AW-1:0] to_waddr(input logic [11:0] idx);
    logic [31:0] t;
    t = 32'(idx);
    return t[W_AW-1:0];
  endfunction

endpackage

FILE: design/slt_iter_unit.sv
// Shared multi-cycle unit: restoring divide (one quotient bit a cycle) and
// integer square root (one result bit a cycle). Depends on slt_pkg.
module slt_iter_unit import slt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  iter_req_t req_i,
  output iter_rsp_t rsp_o
);

  logic        busy_q, done_q;
  iter_op_e    op_q;
  logic [5:0]  cnt_q;
  logic [63:0] dvd_q, quo_q;
  logic [32:0] dvs_q;
  logic [33:0] rem_q, bit_q;

  logic [33:0] rem_sh, rem_sub, trial;
  logic        div_ge, sq_ge;

  // Form one divide step and one root step
  always_comb begin
    rem_sh  = {rem_q[32:0], dvd_q[63]};
    div_ge  = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
    trial   = quo_q[33:0] + bit_q;
    sq_ge   = rem_q >= trial;
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= (req_i.op == IT_DIV) ? 6'(DIV_STEPS - 1) : 6'(SQRT_STEPS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Advance the datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      dvd_q <= req_i.a;
      dvs_q <= req_i.b;
      rem_q <= (req_i.op == IT_DIV) ? 34'd0 : {1'b0, req_i.a[32:0]};
      quo_q <= '0;
      bit_q <= 34'd1 << 32;
    end else if (busy_q) begin
      unique case (op_q)
        IT_DIV: begin
          dvd_q <= {dvd_q[62:0], 1'b0};
          rem_q <= div_ge ? rem_sub : rem_sh;
          quo_q <= {quo_q[62:0], div_ge};
        end
        IT_SQRT: begin
          if (sq_ge) begin
            rem_q <= rem_q - trial;
            quo_q <= 64'({1'b0, quo_q[33:1]} + bit_q);
          end else begin
            quo_q <= quo_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
        default: ;
      endcase
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = quo_q;

endmodule

FILE: design/slt_sig_rom.sv
// Sigmoid lookup with registered read data.
// Depends on slt_pkg for the table contents.
module slt_sig_rom import slt_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SIG_AW-1:0] addr_i,
  output logic [16:0]       data_o
);

  // Register the looked-up entry
  always_ff @(posedge clk_i) begin
    if (en_i) data_o <= SIG_TABLE[addr_i];
  end

endmodule

FILE: design/sparse_logistic_l1_trainer.sv
// Top level of the sparse logistic trainer: sequencer, shared multiplier,
// weight table, sample buffer. Depends on slt_pkg, slt_iter_unit, slt_sig_rom.
//
//  channel   direction  handshake                  payload
//  input     in         in_valid_i / in_ready_o    opcode, feature_index/value, label
//  result    out        out_valid_o / out_ready_i  kind, probability, weight, count, flag
//  config    in         cfg_we_i                   cfg_wdata_i (l1_strength)
//
// Feature element: taken in the idle state. Weight read: registered table read, then
// the result register. Sample end: per buffered feature, buffer read, weight read,
// multiply, accumulate for the dot product, then per feature buffer read, weight read,
// multiply, write for the update, with sigmoid and step between; the shared multiplier
// and single weight port take the features one at a time. Epoch end: the sweep over
// every weight plus the divides and square root. After reset a clearing pass writes
// zero to every weight with in_ready_o low. A stalled result holds; the next item is still taken.
`include "assert_macros.svh"

module sparse_logistic_l1_trainer import slt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [11:0] feature_index_i,
  input  logic signed [31:0] feature_value_i,
  input  logic        click_label_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [16:0] probability_o,
  output logic signed [31:0] weight_value_o,
  output logic [12:0] nonzero_count_o,
  output logic        buffer_overflow_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam logic signed [ACC_W-1:0] SIX_Z = ACC_W'(SIX_Q16);

  state_e state_q, state_d;
  opcode_e op;

  logic [31:0] lambda_q, epoch_q, samples_q, rate_q, thr_q;
  logic signed [31:0] bias_q;
  logic [CNT_W-1:0] buf_cnt_q, elem_q;
  logic ovf_q, label_q;
  logic [W_AW-1:0] wcnt_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [N_W-1:0] n_q;
  logic [16:0] p_q;
  logic signed [17:0] rg_q;
  logic [12:0] nz_q;
  kind_e kind_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_q;

  logic [W_AW+31:0] buf_mem [MAX_ACTIVE];
  logic [W_AW+31:0] buf_rd_q;
  logic buf_re;
  logic [W_AW-1:0] buf_idx;
  logic signed [31:0] buf_val;

  logic signed [31:0] w_mem [NUM_FEATURES];
  logic signed [31:0] w_rd_q;
  logic w_re, w_we;
  logic [W_AW-1:0] w_raddr, w_waddr;
  logic [31:0] w_wdata;

  iter_req_t iter_req;
  iter_rsp_t iter_rsp;

  logic [16:0] rom_data;
  logic rom_en;
  logic [SIG_AW-1:0] k_addr;

  logic accept, emit_go, elem_last, w_last, buf_full, iter_wait;
  logic signed [17:0] err;
  logic signed [35:0] d_upd, w_diff, b_diff;
  logic [31:0] st_w;
  logic [X_W-1:0] x_v;
  logic [X_W+15:0] q_prod;
  logic [X_W-1:0] q0, r_v;
  logic signed [65:0] mul_sh;
  logic [19:0] off_v;

  logic out_valid_q, ovf_out_q;
  logic [1:0] kind_out_q;
  logic [16:0] prob_out_q;
  logic [31:0] wv_out_q;
  logic [12:0] nz_out_q;

  assign op        = opcode_e'(opcode_i);
  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign emit_go   = !out_valid_q || out_ready_i;
  assign elem_last = (elem_q + CNT_W'(1)) == buf_cnt_q;
  assign w_last    = wcnt_q == W_AW'(NUM_FEATURES - 1);
  assign buf_full  = buf_cnt_q >= CNT_W'(MAX_ACTIVE);
  assign buf_idx   = buf_rd_q[W_AW+31:32];
  assign buf_val   = buf_rd_q[31:0];
  assign iter_wait = (state_q == ST_EP_DIVW) || (state_q == ST_EP_RATEW) ||
                     (state_q == ST_EP_SQW);

  // Form the arithmetic around the shared multiplier
  always_comb begin
    err    = $signed({1'b0, p_q}) - (label_q ? 18'sd65536 : 18'sd0);
    mul_sh = mul_q >>> 16;
    d_upd  = mul_q[51:16];
    w_diff = 36'(w_rd_q) - d_upd;
    b_diff = 36'(bias_q) - 36'(rg_q);
    st_w   = soft_thr(w_rd_q, thr_q);
    off_v  = 20'(acc_q + SIX_Z);
    x_v    = n_q[N_W-1:18];
    q_prod = (X_W+16)'(x_v) * (X_W+16)'(21845);
    q0     = q_prod[X_W+15:16];
    r_v    = x_v - X_W'(3 * q0);
    k_addr = (r_v >= X_W'(3)) ? SIG_AW'(q0 + X_W'(1)) : SIG_AW'(q0);
  end

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_DOT_MUL: begin mul_a = 33'(w_rd_q); mul_b = 33'(buf_val); end
      ST_RG_MUL:  begin mul_a = 33'(err);    mul_b = {1'b0, rate_q}; end
      ST_UPD_MUL: begin mul_a = 33'(rg_q);   mul_b = 33'(buf_val); end
      ST_EP_MUL:  begin mul_a = {1'b0, lambda_q}; mul_b = {1'b0, samples_q}; end
      default: ;
    endcase
  end

  // Register the product
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else         state_q <= state_d;
  end

  // Next state and memory and unit controls
  always_comb begin
    state_d  = state_q;
    buf_re   = 1'b0;
    w_re     = 1'b0;
    w_raddr  = to_waddr(feature_index_i);
    w_we     = 1'b0;
    w_waddr  = wcnt_q;
    w_wdata  = 32'd0;
    rom_en   = 1'b0;
    iter_req = '{start: 1'b0, op: IT_DIV, a: 64'd0, b: 33'd0};
    unique case (state_q)
      ST_CLEAR: begin
        w_we = 1'b1;
        if (w_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_FEATURE:     state_d = ST_IDLE;
            OP_SAMPLE_END:  state_d = (buf_cnt_q == '0) ? ST_SIG0 : ST_DOT_BRD;
            OP_EPOCH_END:   state_d = ST_EP_MUL;
            OP_WEIGHT_READ: begin
              w_re    = 1'b1;
              state_d = ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_DOT_BRD: begin buf_re = 1'b1; state_d = ST_DOT_WRD; end
      ST_DOT_WRD: begin w_re = 1'b1; w_raddr = buf_idx; state_d = ST_DOT_MUL; end
      ST_DOT_MUL: state_d = ST_DOT_ACC;
      ST_DOT_ACC: state_d = elem_last ? ST_SIG0 : ST_DOT_BRD;
      ST_SIG0: begin
        if (acc_q > SIX_Z || acc_q < -SIX_Z) state_d = ST_RG_MUL;
        else                                 state_d = ST_SIG1;
      end
      ST_SIG1: begin rom_en = 1'b1; state_d = ST_SIG2; end
      ST_SIG2: state_d = ST_RG_MUL;
      ST_RG_MUL: state_d = ST_RG_CAP;
      ST_RG_CAP: state_d = (buf_cnt_q == '0) ? ST_EMIT : ST_UPD_BRD;
      ST_UPD_BRD: begin buf_re = 1'b1; state_d = ST_UPD_WRD; end
      ST_UPD_WRD: begin w_re = 1'b1; w_raddr = buf_idx; state_d = ST_UPD_MUL; end
      ST_UPD_MUL: state_d = ST_UPD_WR;
      ST_UPD_WR: begin
        w_we    = 1'b1;
        w_waddr = buf_idx;
        w_wdata = sat32(w_diff);
        state_d = elem_last ? ST_EMIT : ST_UPD_BRD;
      end
      ST_EP_MUL: state_d = ST_EP_DIV;
      ST_EP_DIV: begin
        if (samples_q == 32'd0) begin
          state_d = ST_SW_RD;
        end else begin
          iter_req = '{start: 1'b1, op: IT_DIV, a: mul_q[63:0],
                       b: 33'(samples_q) + 33'(epoch_q)};
          state_d  = ST_EP_DIVW;
        end
      end
      ST_EP_DIVW: if (iter_rsp.done) state_d = ST_SW_RD;
      ST_SW_RD: begin w_re = 1'b1; w_raddr = wcnt_q; state_d = ST_SW_WR; end
      ST_SW_WR: begin
        w_we    = 1'b1;
        w_wdata = st_w;
        state_d = w_last ? ST_EP_BIAS : ST_SW_RD;
      end
      ST_EP_BIAS: state_d = ST_EP_RATE;
      ST_EP_RATE: begin
        iter_req = '{start: 1'b1, op: IT_DIV, a: 64'd1 << 32, b: {1'b0, epoch_q}};
        state_d  = ST_EP_RATEW;
      end
      ST_EP_RATEW: begin
        if (iter_rsp.done) begin
          iter_req = '{start: 1'b1, op: IT_SQRT, a: iter_rsp.result, b: 33'd0};
          state_d  = ST_EP_SQW;
        end
      end
      ST_EP_SQW: if (iter_rsp.done) state_d = ST_EMIT;
      ST_EMIT:   if (emit_go) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sample buffer: write on feature items, registered read
  always_ff @(posedge clk_i) begin
    if (accept && op == OP_FEATURE && !buf_full)
      buf_mem[buf_cnt_q[BUF_AW-1:0]] <= {to_waddr(feature_index_i), feature_value_i};
    if (buf_re) buf_rd_q <= buf_mem[elem_q[BUF_AW-1:0]];
  end

  // Weight table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (w_we) w_mem[w_waddr] <= w_wdata;
    if (w_re) w_rd_q <= w_mem[w_raddr];
  end

  // Control and model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q  <= 32'd0;
      bias_q    <= 32'sd0;
      buf_cnt_q <= '0;
      ovf_q     <= 1'b0;
      epoch_q   <= 32'd1;
      samples_q <= 32'd0;
      rate_q    <= 32'd65536;
      wcnt_q    <= '0;
      elem_q    <= '0;
      nz_q      <= '0;
    end else begin
      if (cfg_we_i) lambda_q <= cfg_wdata_i;
      unique case (state_q)
        ST_CLEAR: wcnt_q <= wcnt_q + W_AW'(1);
        ST_IDLE: begin
          elem_q <= '0;
          if (accept && op == OP_FEATURE) begin
            if (buf_full) ovf_q <= 1'b1;
            else          buf_cnt_q <= buf_cnt_q + CNT_W'(1);
          end
        end
        ST_DOT_ACC: elem_q <= elem_last ? '0 : elem_q + CNT_W'(1);
        ST_UPD_WR: begin
          bias_q <= sat32(b_diff);
          elem_q <= elem_q + CNT_W'(1);
        end
        ST_EP_DIV: begin
          wcnt_q <= '0;
          nz_q   <= '0;
        end
        ST_SW_WR: begin
          wcnt_q <= wcnt_q + W_AW'(1);
          if (st_w != 32'd0 && nz_q != 13'h1FFF) nz_q <= nz_q + 13'd1;
        end
        ST_EP_BIAS: begin
          bias_q    <= soft_thr(bias_q, thr_q);
          samples_q <= 32'd0;
          if (epoch_q != 32'hFFFF_FFFF) epoch_q <= epoch_q + 32'd1;
        end
        ST_EP_SQW: if (iter_rsp.done) rate_q <= iter_rsp.result[31:0];
        ST_EMIT: begin
          if (emit_go && kind_q == KIND_PRED) begin
            buf_cnt_q <= '0;
            ovf_q     <= 1'b0;
            if (samples_q != 32'hFFFF_FFFF) samples_q <= samples_q + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Per-item working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      label_q <= click_label_i;
      acc_q   <= ACC_W'(bias_q);
      unique case (op)
        OP_EPOCH_END:   kind_q <= KIND_EPOCH;
        OP_WEIGHT_READ: kind_q <= KIND_READ;
        default:        kind_q <= KIND_PRED;
      endcase
    end
    unique case (state_q)
      ST_DOT_ACC: acc_q <= acc_q + $signed(mul_sh[ACC_W-1:0]);
      ST_SIG0: begin
        if (acc_q > SIX_Z)       p_q <= 17'd65536;
        else if (acc_q < -SIX_Z) p_q <= 17'd0;
        n_q <= N_W'(off_v) * N_W'(SIGMOID_ENTRIES - 1) + N_W'(SIX_Q16);
      end
      ST_SIG2:    p_q <= rom_data;
      ST_RG_CAP:  rg_q <= mul_q[33:16];
      ST_EP_DIV:  if (samples_q == 32'd0) thr_q <= 32'd0;
      ST_EP_DIVW: if (iter_rsp.done) thr_q <= iter_rsp.result[31:0];
      default: ;
    endcase
  end

  // Result register: load when the slot is free, drop valid when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && emit_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && emit_go) begin
      kind_out_q <= kind_q;
      prob_out_q <= (kind_q == KIND_PRED) ? p_q : 17'd0;
      ovf_out_q  <= (kind_q == KIND_PRED) ? ovf_q : 1'b0;
      nz_out_q   <= (kind_q == KIND_EPOCH) ? nz_q : 13'd0;
      unique case (kind_q)
        KIND_EPOCH: wv_out_q <= bias_q;
        KIND_READ:  wv_out_q <= w_rd_q;
        default:    wv_out_q <= 32'd0;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = kind_out_q;
  assign probability_o     = prob_out_q;
  assign weight_value_o    = wv_out_q;
  assign nonzero_count_o   = nz_out_q;
  assign buffer_overflow_o = ovf_out_q;

  slt_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req),
    .rsp_o  (iter_rsp)
  );

  slt_sig_rom u_sig (
    .clk_i  (clk_i),
    .en_i   (rom_en),
    .addr_i (k_addr),
    .data_o (rom_data)
  );

  // Checks on sequencer and datapath
  `SLT_ASSERT(a_buf_cnt_bound, buf_cnt_q <= CNT_W'(MAX_ACTIVE))
  `SLT_ASSERT_IMPLY(a_iter_done_wait, iter_rsp.done, iter_wait)
  `SLT_ASSERT_IMPLY(a_prob_range, out_valid_o, probability_o <= 17'd65536)
  `SLT_ASSERT(a_full_drop, (accept && (opcode_i == 2'(OP_FEATURE)) && buf_full) |=> ovf_q)

endmodule
